/* sv/bhd_pkg.sv */
`default_nettype none

package bhd_pkg;

  // Fixed field widths
  localparam int NODE_W  = 6;
  localparam int CFG_W   = 7;
  localparam int PDATA_W = 32;
  localparam int PADDR_W = 3;

  // Command codes
  localparam logic MODE_ADD_EDGE = 1'b0;
  localparam logic MODE_QUERY    = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_NODE_COUNT = 1'b0;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef struct packed {
    logic              mode;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } bhd_cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0] target_node;
    logic [NODE_W-1:0] stops_between;
    logic              reachable;
    logic              last;
  } bhd_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_RD,
    ST_EDGE_WA,
    ST_EDGE_WB,
    ST_Q_INIT,
    ST_Q_POP,
    ST_Q_FETCH,
    ST_Q_LOAD,
    ST_Q_SCAN,
    ST_Q_EMIT
  } bhd_state_t;

endpackage

`default_nettype wire

/* sv/bhd_first_one.sv */
`default_nettype none

// Lowest set bit of a vector: one-hot mask and its index
module bhd_first_one #(
  parameter int N  = 64,
  parameter int AW = 6
) (
  input  wire  logic [N-1:0]  vec,
  output logic               found,
  output logic [N-1:0]       onehot,
  output logic [AW-1:0]      idx
);

  // Two's complement trick isolates the lowest one
  assign onehot = vec & (~vec + N'(1));
  assign found  = |vec;

  // Encode the one-hot mask
  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (onehot[i]) begin
        idx = idx | AW'(i);
      end
    end
  end

endmodule

`default_nettype wire

/* sv/bhd_adj_store.sv */
`default_nettype none

// Adjacency row memory with per-row valid bits; an invalid row reads as zero
module bhd_adj_store #(
  parameter int N  = 64,
  parameter int AW = 6
) (
  input  wire  logic          clk,
  input  wire  logic          rst,
  input  wire  logic [AW-1:0] rd_addr,
  output logic [N-1:0]        rd_row,
  input  wire  logic          we,
  input  wire  logic [AW-1:0] waddr,
  input  wire  logic [N-1:0]  wrow
);

  logic [N-1:0] mem [N];
  logic [N-1:0] row_valid;
  logic [N-1:0] rd_q;
  logic         rd_valid_q;

  // Row storage, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wrow;
    end
    rd_q <= mem[rd_addr];
  end

  // Valid bits; sampled with the read so a same-cycle write is not seen
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we) begin
        row_valid[waddr] <= 1'b1;
      end
      rd_valid_q <= row_valid[rd_addr];
    end
  end

  assign rd_row = rd_valid_q ? rd_q : '0;

endmodule

`default_nettype wire

/* sv/bfs_hop_distance_engine.sv */
// Hop-distance engine: breadth-first search over an undirected graph.
// Command channel: an item transfers on a rising edge with start high and
// busy low. mode add-edge sets both directions of an edge (endpoints at or
// above MAX_NODES are dropped) and produces no result; busy stays high for
// the read-modify-write of two adjacency rows through one port.
// mode query searches from node_a and then reports every node below the
// effective node count in order, one result per cycle on res, marked by
// res_valid for one cycle, last set on the final one.
// Query steps: for each reached node a queue pop, row fetch, row load
// and closing scan, plus one scan step per newly found node; a setup
// step comes first, a final empty pop ends the search, then one result
// per node in use. The single row memory port sets the pace.
// The final result shows in the cycle busy falls. The receiver cannot
// stall; results are never held back.
// Reset clears the graph (row valid bits, no sweep) and sets node_count to
// 64. node_count is written over the APB port at address 0, by the user
// only while idle; the block itself does not enforce it.
`default_nettype none

module bfs_hop_distance_engine #(
  parameter int MAX_NODES = 64
) (
  input  wire  logic                          clk,
  input  wire  logic                          rst,
  input  wire  logic                          start,
  output logic                                busy,
  input  wire  bhd_pkg::bhd_cmd_t             cmd,
  output logic                                res_valid,
  output bhd_pkg::bhd_res_t                   res,
  input  wire  logic                          psel,
  input  wire  logic                          penable,
  input  wire  logic                          pwrite,
  input  wire  logic [bhd_pkg::PADDR_W-1:0]   paddr,
  input  wire  logic [bhd_pkg::PDATA_W-1:0]   pwdata,
  output logic [bhd_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int N  = MAX_NODES;
  localparam int AW = (N > 1) ? $clog2(N) : 1;
  localparam int CW = $clog2(N + 1);
  localparam int NW = bhd_pkg::NODE_W;
  localparam int FW = bhd_pkg::CFG_W;

  bhd_pkg::bhd_state_t state, state_next;
  bhd_pkg::bhd_cmd_t   cmd_q;

  logic [FW-1:0] node_count;
  logic [CW-1:0] count_eff, count_q;
  logic [CW-1:0] head, tail;
  logic [N-1:0]  visited, fresh, lim;
  logic [NW-1:0] ucost;
  logic [AW-1:0] emit_idx;

  logic          e_vld, e_seen, e_last;
  logic [AW-1:0] e_idx;

  logic          accept, edge_ok, src_ok, head_empty, emit_last;

  // Memory control
  logic [AW-1:0] adj_raddr, adj_waddr;
  logic          adj_we;
  logic [N-1:0]  adj_wrow, adj_row;
  logic          q_we;
  logic [AW-1:0] q_waddr, q_wdata, q_rd;
  logic          d_we;
  logic [AW-1:0] d_waddr, d_raddr;
  logic [NW-1:0] d_wdata, d_rd;

  logic [AW-1:0] queue_mem [N];
  logic [NW-1:0] dist_mem [N];

  logic          fo_found;
  logic [N-1:0]  fo_onehot;
  logic [AW-1:0] fo_idx;

  logic [AW-1:0] a_idx, b_idx;

  // Config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= bhd_pkg::NODE_COUNT_RST;
    end else if (psel && penable && pwrite && paddr[2] == bhd_pkg::REG_NODE_COUNT) begin
      node_count <= pwdata[FW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == bhd_pkg::REG_NODE_COUNT) begin
      prdata = {{(bhd_pkg::PDATA_W - FW){1'b0}}, node_count};
    end
  end

  // Clamp node count into 1..MAX_NODES
  always_comb begin
    if (node_count == '0) begin
      count_eff = CW'(1);
    end else if (node_count > FW'(N)) begin
      count_eff = CW'(N);
    end else begin
      count_eff = CW'(node_count);
    end
  end

  // Node mask below the latched count
  always_comb begin
    for (int i = 0; i < N; i++) begin
      lim[i] = (FW'(i) < FW'(count_q));
    end
  end

  assign accept     = start && !busy;
  assign busy       = (state != bhd_pkg::ST_IDLE);
  assign edge_ok    = ({1'b0, cmd.node_a} < FW'(N)) && ({1'b0, cmd.node_b} < FW'(N));
  assign src_ok     = ({1'b0, cmd_q.node_a} < FW'(count_q));
  assign head_empty = (head == tail);
  assign emit_last  = ((CW'(emit_idx) + CW'(1)) == count_q);
  assign a_idx      = cmd_q.node_a[AW-1:0];
  assign b_idx      = cmd_q.node_b[AW-1:0];

  // Shared lowest-one finder over the fresh neighbor set
  bhd_first_one #(.N(N), .AW(AW)) u_first_one (
    .vec    (fresh),
    .found  (fo_found),
    .onehot (fo_onehot),
    .idx    (fo_idx)
  );

  bhd_adj_store #(.N(N), .AW(AW)) u_adj_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (adj_raddr),
    .rd_row  (adj_row),
    .we      (adj_we),
    .waddr   (adj_waddr),
    .wrow    (adj_wrow)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bhd_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd.mode == bhd_pkg::MODE_QUERY) begin
            state_next = bhd_pkg::ST_Q_INIT;
          end else if (edge_ok) begin
            state_next = bhd_pkg::ST_EDGE_RD;
          end
        end
      end
      bhd_pkg::ST_EDGE_RD: state_next = bhd_pkg::ST_EDGE_WA;
      bhd_pkg::ST_EDGE_WA: state_next = bhd_pkg::ST_EDGE_WB;
      bhd_pkg::ST_EDGE_WB: state_next = bhd_pkg::ST_IDLE;
      bhd_pkg::ST_Q_INIT:  state_next = bhd_pkg::ST_Q_POP;
      bhd_pkg::ST_Q_POP: begin
        state_next = head_empty ? bhd_pkg::ST_Q_EMIT : bhd_pkg::ST_Q_FETCH;
      end
      bhd_pkg::ST_Q_FETCH: state_next = bhd_pkg::ST_Q_LOAD;
      bhd_pkg::ST_Q_LOAD:  state_next = bhd_pkg::ST_Q_SCAN;
      bhd_pkg::ST_Q_SCAN: begin
        if (!fo_found) begin
          state_next = bhd_pkg::ST_Q_POP;
        end
      end
      bhd_pkg::ST_Q_EMIT: begin
        if (emit_last) begin
          state_next = bhd_pkg::ST_IDLE;
        end
      end
      default: state_next = bhd_pkg::ST_IDLE;
    endcase
  end

  // Memory port control per state
  always_comb begin
    adj_raddr = a_idx;
    adj_we    = 1'b0;
    adj_waddr = a_idx;
    adj_wrow  = adj_row;
    q_we      = 1'b0;
    q_waddr   = tail[AW-1:0];
    q_wdata   = fo_idx;
    d_we      = 1'b0;
    d_waddr   = fo_idx;
    d_wdata   = ucost;
    d_raddr   = q_rd;
    unique case (state)
      bhd_pkg::ST_EDGE_WA: begin
        adj_we    = 1'b1;
        adj_waddr = a_idx;
        adj_wrow  = adj_row | (N'(1) << b_idx);
        adj_raddr = b_idx;
      end
      bhd_pkg::ST_EDGE_WB: begin
        adj_we    = 1'b1;
        adj_waddr = b_idx;
        adj_wrow  = adj_row | (N'(1) << a_idx);
      end
      bhd_pkg::ST_Q_INIT: begin
        q_we    = src_ok;
        q_waddr = '0;
        q_wdata = a_idx;
        d_we    = src_ok;
        d_waddr = a_idx;
        d_wdata = '0;
      end
      bhd_pkg::ST_Q_FETCH: begin
        adj_raddr = q_rd;
        d_raddr   = q_rd;
      end
      bhd_pkg::ST_Q_SCAN: begin
        q_we = fo_found;
        d_we = fo_found;
      end
      bhd_pkg::ST_Q_EMIT: begin
        d_raddr = emit_idx;
      end
      default: begin
      end
    endcase
  end

  // Frontier queue and distance memories, registered reads
  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    q_rd <= queue_mem[head[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dist_mem[d_waddr] <= d_wdata;
    end
    d_rd <= dist_mem[d_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bhd_pkg::ST_IDLE;
      e_vld <= 1'b0;
    end else begin
      state <= state_next;
      e_vld <= (state == bhd_pkg::ST_Q_EMIT);
    end
  end

  // Search datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      count_q <= count_eff;
    end
    unique case (state)
      bhd_pkg::ST_Q_INIT: begin
        head     <= '0;
        tail     <= src_ok ? CW'(1) : '0;
        visited  <= src_ok ? (N'(1) << a_idx) : '0;
        emit_idx <= '0;
      end
      bhd_pkg::ST_Q_POP: begin
        if (!head_empty) begin
          head <= head + CW'(1);
        end
      end
      bhd_pkg::ST_Q_LOAD: begin
        fresh   <= adj_row & lim & ~visited;
        visited <= visited | (adj_row & lim);
        ucost   <= d_rd + NW'(1);
      end
      bhd_pkg::ST_Q_SCAN: begin
        if (fo_found) begin
          fresh <= fresh & ~fo_onehot;
          tail  <= tail + CW'(1);
        end
      end
      bhd_pkg::ST_Q_EMIT: begin
        emit_idx <= emit_idx + AW'(1);
        e_idx    <= emit_idx;
        e_seen   <= visited[emit_idx];
        e_last   <= emit_last;
      end
      default: begin
      end
    endcase
  end

  // Result transfer, distance data arrives in the cycle after the read
  assign res_valid         = e_vld;
  assign res.target_node   = NW'(e_idx);
  assign res.stops_between = (e_seen && d_rd != '0) ? (d_rd - NW'(1)) : '0;
  assign res.reachable     = e_seen;
  assign res.last          = e_last;

endmodule

`default_nettype wire
